### hw/rtl/ps2a_pkg.sv
package ps2a_pkg;

  localparam logic [7:0] PREFIX_EXT = 8'hE0;
  localparam logic [7:0] PREFIX_REL = 8'hF0;
  localparam logic [7:0] KEY_LSHIFT = 8'h12;
  localparam logic [7:0] KEY_RSHIFT = 8'h59;
  localparam logic [7:0] KEY_SPACE  = 8'h29;
  localparam logic [7:0] KEY_BKSP   = 8'h66;
  localparam logic [7:0] KEY_CAPS   = 8'h58;
  localparam logic [7:0] CODE_MAX   = 8'd131;

  localparam logic [6:0] CHAR_NONE  = 7'h00;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_BKSP  = 7'h08;
  localparam logic [6:0] CASE_BIT   = 7'h20;

  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_EXT  = 3'b010,
    PH_REL  = 3'b100
  } phase_t;

  typedef struct packed {
    logic   left_shift_down;
    logic   right_shift_down;
    logic   caps_lock_on;
    phase_t prefix_phase;
  } kbd_state_t;

  function automatic logic [6:0] plain_char(input logic [7:0] code);
    logic [6:0] ch;
    ch = CHAR_NONE;
    unique case (code)
      8'h0D: ch = 7'h09;
      8'h0E: ch = 7'h60;
      8'h15: ch = 7'h71;
      8'h16: ch = 7'h31;
      8'h1A: ch = 7'h7A;
      8'h1B: ch = 7'h73;
      8'h1C: ch = 7'h61;
      8'h1D: ch = 7'h77;
      8'h1E: ch = 7'h32;
      8'h21: ch = 7'h63;
      8'h22: ch = 7'h78;
      8'h23: ch = 7'h64;
      8'h24: ch = 7'h65;
      8'h25: ch = 7'h34;
      8'h26: ch = 7'h33;
      8'h2A: ch = 7'h76;
      8'h2B: ch = 7'h66;
      8'h2C: ch = 7'h74;
      8'h2D: ch = 7'h72;
      8'h2E: ch = 7'h35;
      8'h31: ch = 7'h6E;
      8'h32: ch = 7'h62;
      8'h33: ch = 7'h68;
      8'h34: ch = 7'h67;
      8'h35: ch = 7'h79;
      8'h36: ch = 7'h36;
      8'h3A: ch = 7'h6D;
      8'h3B: ch = 7'h6A;
      8'h3C: ch = 7'h75;
      8'h3D: ch = 7'h37;
      8'h3E: ch = 7'h38;
      8'h41: ch = 7'h2C;
      8'h42: ch = 7'h6B;
      8'h43: ch = 7'h69;
      8'h44: ch = 7'h6F;
      8'h45: ch = 7'h30;
      8'h46: ch = 7'h39;
      8'h49: ch = 7'h2E;
      8'h4A: ch = 7'h2F;
      8'h4B: ch = 7'h6C;
      8'h4C: ch = 7'h3B;
      8'h4D: ch = 7'h70;
      8'h4E: ch = 7'h2D;
      8'h52: ch = 7'h27;
      8'h54: ch = 7'h5B;
      8'h55: ch = 7'h3D;
      8'h5A: ch = 7'h0A;
      8'h5B: ch = 7'h5D;
      8'h5D: ch = 7'h5C;
      8'h66: ch = 7'h08;
      8'h76: ch = 7'h1B;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [7:0] code);
    logic [6:0] ch;
    ch = CHAR_NONE;
    unique case (code)
      8'h0E: ch = 7'h7E;
      8'h15: ch = 7'h51;
      8'h16: ch = 7'h21;
      8'h1A: ch = 7'h5A;
      8'h1B: ch = 7'h53;
      8'h1C: ch = 7'h41;
      8'h1D: ch = 7'h57;
      8'h1E: ch = 7'h40;
      8'h21: ch = 7'h43;
      8'h22: ch = 7'h58;
      8'h23: ch = 7'h44;
      8'h24: ch = 7'h45;
      8'h25: ch = 7'h24;
      8'h26: ch = 7'h23;
      8'h2A: ch = 7'h56;
      8'h2B: ch = 7'h46;
      8'h2C: ch = 7'h54;
      8'h2D: ch = 7'h52;
      8'h2E: ch = 7'h25;
      8'h31: ch = 7'h4E;
      8'h32: ch = 7'h42;
      8'h33: ch = 7'h48;
      8'h34: ch = 7'h47;
      8'h35: ch = 7'h59;
      8'h36: ch = 7'h5E;
      8'h3A: ch = 7'h4D;
      8'h3B: ch = 7'h4A;
      8'h3C: ch = 7'h55;
      8'h3D: ch = 7'h26;
      8'h3E: ch = 7'h2A;
      8'h41: ch = 7'h3C;
      8'h42: ch = 7'h4B;
      8'h43: ch = 7'h49;
      8'h44: ch = 7'h4F;
      8'h45: ch = 7'h29;
      8'h46: ch = 7'h28;
      8'h49: ch = 7'h3E;
      8'h4A: ch = 7'h3F;
      8'h4B: ch = 7'h4C;
      8'h4C: ch = 7'h3A;
      8'h4D: ch = 7'h50;
      8'h4E: ch = 7'h5F;
      8'h52: ch = 7'h22;
      8'h54: ch = 7'h7B;
      8'h55: ch = 7'h2B;
      8'h5A: ch = 7'h0A;
      8'h5B: ch = 7'h7D;
      8'h5D: ch = 7'h7C;
      8'h66: ch = 7'h08;
      8'h76: ch = 7'h1B;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

  function automatic logic is_letter(input logic [6:0] ch);
    return ((ch >= 7'h61) && (ch <= 7'h7A)) || ((ch >= 7'h41) && (ch <= 7'h5A));
  endfunction

endpackage

### hw/rtl/ps2a_scan_if.sv
interface ps2a_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

### hw/rtl/ps2a_char_if.sv
interface ps2a_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;

  modport source (output valid, output ascii_char, input ready);
  modport sink (input valid, input ascii_char, output ready);
endinterface

### hw/rtl/ps2a_xlate.sv
module ps2a_xlate #(
  parameter int TABLE_SIZE = 132
) (
  input  ps2a_pkg::kbd_state_t cur,
  input  logic [7:0]           code,
  output ps2a_pkg::kbd_state_t nxt,
  output logic                 emit,
  output logic [6:0]           ascii_char
);

  logic       released;
  logic       in_range;
  logic       shift_any;
  logic       caps_eff;
  logic [6:0] rom_ch;
  logic [6:0] look_ch;

  assign in_range  = (code != 8'd0) && (code <= ps2a_pkg::CODE_MAX)
                     && ({1'b0, code} < 9'(TABLE_SIZE));
  assign shift_any = cur.left_shift_down | cur.right_shift_down;
  assign rom_ch    = shift_any ? ps2a_pkg::shifted_char(code) : ps2a_pkg::plain_char(code);

  // caps lock press toggles before the lookup
  assign caps_eff  = (code == ps2a_pkg::KEY_CAPS) ? ~cur.caps_lock_on : cur.caps_lock_on;

  always_comb begin
    look_ch = ps2a_pkg::CHAR_NONE;
    if (in_range) begin
      look_ch = rom_ch;
      if (caps_eff && ps2a_pkg::is_letter(rom_ch)) begin
        look_ch = rom_ch ^ ps2a_pkg::CASE_BIT;
      end
    end
  end

  always_comb begin
    nxt        = cur;
    emit       = 1'b0;
    released   = 1'b0;
    ascii_char = ps2a_pkg::CHAR_NONE;
    unique case (cur.prefix_phase)
      ps2a_pkg::PH_NONE: begin
        if (code == ps2a_pkg::PREFIX_EXT) begin
          nxt.prefix_phase = ps2a_pkg::PH_EXT;
        end else if (code == ps2a_pkg::PREFIX_REL) begin
          nxt.prefix_phase = ps2a_pkg::PH_REL;
        end else begin
          emit = 1'b1;
        end
      end
      ps2a_pkg::PH_EXT: begin
        if (code == ps2a_pkg::PREFIX_REL) begin
          nxt.prefix_phase = ps2a_pkg::PH_REL;
        end else begin
          emit             = 1'b1;
          released         = 1'b1;
          nxt.prefix_phase = ps2a_pkg::PH_NONE;
        end
      end
      ps2a_pkg::PH_REL: begin
        emit             = 1'b1;
        released         = 1'b1;
        nxt.prefix_phase = ps2a_pkg::PH_NONE;
      end
      default: begin
        nxt.prefix_phase = ps2a_pkg::PH_NONE;
      end
    endcase

    if (emit) begin
      unique case (code)
        ps2a_pkg::KEY_LSHIFT: nxt.left_shift_down = ~released;
        ps2a_pkg::KEY_RSHIFT: nxt.right_shift_down = ~released;
        ps2a_pkg::KEY_SPACE: begin
          ascii_char = released ? ps2a_pkg::CHAR_NONE : ps2a_pkg::CHAR_SPACE;
        end
        ps2a_pkg::KEY_BKSP: begin
          ascii_char = released ? ps2a_pkg::CHAR_NONE : ps2a_pkg::CHAR_BKSP;
        end
        ps2a_pkg::KEY_CAPS: begin
          if (!released) begin
            nxt.caps_lock_on = ~cur.caps_lock_on;
          end
          ascii_char = released ? ps2a_pkg::CHAR_NONE : look_ch;
        end
        default: begin
          ascii_char = released ? ps2a_pkg::CHAR_NONE : look_ch;
        end
      endcase
    end
  end

endmodule

### hw/rtl/ps2_set2_scancode_to_ascii.sv
// channel  dir  payload            note
// scan     in   scan_byte[7:0]     raw keyboard bytes, prefixes included
// chars    out  ascii_char[6:0]    one per completed code, 0 = no character
//
// one byte per cycle unless chars stalls; a completed code is offered from the output register
// pipeline: input byte register, then lookup and flag update into the output register
// prefix bytes update the prefix state and produce no transfer on chars
// reset clears shift, caps lock and prefix state and empties both registers
// a stall on chars holds the result; the input register still takes a byte when it can drain
module ps2_set2_scancode_to_ascii #(
  parameter int TABLE_SIZE = 132
) (
  input  logic              clk,
  input  logic              rst,
  ps2a_scan_if.sink         scan,
  ps2a_char_if.source       chars
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  ps2a_pkg::kbd_state_t state;
  ps2a_pkg::kbd_state_t state_next;
  logic                 x_emit;
  logic [6:0]           x_char;
  logic                 out_valid;
  logic [6:0]           out_char;
  logic                 out_free;
  logic                 s1_adv;
  logic                 s1_load;

  ps2a_xlate #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_xlate (
    .cur        (state),
    .code       (s1_byte),
    .nxt        (state_next),
    .emit       (x_emit),
    .ascii_char (x_char)
  );

  assign out_free    = ~out_valid | chars.ready;
  assign s1_adv      = s1_valid & (~x_emit | out_free);
  assign s1_load     = ~s1_valid | s1_adv;
  assign scan.ready  = s1_load;
  assign chars.valid = out_valid;
  assign chars.ascii_char = out_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid               <= 1'b0;
      out_valid              <= 1'b0;
      state.left_shift_down  <= 1'b0;
      state.right_shift_down <= 1'b0;
      state.caps_lock_on     <= 1'b0;
      state.prefix_phase     <= ps2a_pkg::PH_NONE;
    end else begin
      if (s1_load) begin
        s1_valid <= scan.valid;
      end
      if (s1_adv) begin
        state <= state_next;
      end
      if (s1_adv && x_emit) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && scan.valid) begin
      s1_byte <= scan.scan_byte;
    end
    if (s1_adv && x_emit) begin
      out_char <= x_char;
    end
  end

endmodule

### dv/ps2_set2_scancode_to_ascii_checker.sv
`timescale 1ns / 1ps

module ps2_set2_scancode_to_ascii_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       scan_valid,
  input  logic       scan_ready,
  input  logic [7:0] scan_byte,
  input  logic       char_valid,
  input  logic       char_ready,
  input  logic [6:0] ascii_char,
  output int         errors,
  output int         pending,
  output int         checked
);

  localparam int KEY_COUNT = 51;
  localparam logic [7:0] KEY_TAB = 8'h0D;

  logic [7:0] key_list [KEY_COUNT];
  string      plain_keys;
  string      shifted_keys;
  logic [6:0] plain_map [0:255];
  logic [6:0] shifted_map [0:255];

  logic              lshift_held;
  logic              rshift_held;
  logic              caps_active;
  ps2a_pkg::phase_t  phase;
  logic [6:0]        char_queue [$];

  initial begin
    byte c;
    key_list = '{8'h0D, 8'h0E, 8'h15, 8'h16, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E,
                 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2C,
                 8'h2D, 8'h2E, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h3A,
                 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
                 8'h46, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h52, 8'h54,
                 8'h55, 8'h5A, 8'h5B, 8'h5D, 8'h66, 8'h76};
    plain_keys   = "\t`q1zsaw2cxde43vftr5nbhgy6mju78,kio09./l;p-'[=\n]\\\010\033";
    shifted_keys = "x~Q!ZSAW@CXDE$#VFTR%NBHGY^MJU&*<KIO)(>?L:P_\"{+\n}|\010\033";
    for (int i = 0; i < 256; i++) begin
      plain_map[i]   = ps2a_pkg::CHAR_NONE;
      shifted_map[i] = ps2a_pkg::CHAR_NONE;
    end
    for (int i = 0; i < KEY_COUNT; i++) begin
      c = plain_keys[i];
      plain_map[key_list[i]] = c[6:0];
      c = shifted_keys[i];
      shifted_map[key_list[i]] = c[6:0];
    end
    // tab has no shifted form
    shifted_map[KEY_TAB] = ps2a_pkg::CHAR_NONE;
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  function logic letter(input logic [6:0] ch);
    logic [6:0] lower;
    lower = ch | ps2a_pkg::CASE_BIT;
    return (lower >= 7'h61) && (lower <= 7'h7A);
  endfunction

  // applies a completed code to the key flags and returns its character
  function logic [6:0] finish_code(input logic [7:0] code, input logic released);
    logic [6:0] ch;
    ch = ps2a_pkg::CHAR_NONE;
    case (code)
      ps2a_pkg::KEY_LSHIFT: lshift_held = !released;
      ps2a_pkg::KEY_RSHIFT: rshift_held = !released;
      ps2a_pkg::KEY_SPACE: if (!released) ch = ps2a_pkg::CHAR_SPACE;
      ps2a_pkg::KEY_BKSP: if (!released) ch = ps2a_pkg::CHAR_BKSP;
      default: begin
        if (code == ps2a_pkg::KEY_CAPS && !released) caps_active = !caps_active;
        if (!released && code != 8'd0 && code <= ps2a_pkg::CODE_MAX) begin
          ch = (lshift_held || rshift_held) ? shifted_map[code] : plain_map[code];
          if (caps_active && letter(ch)) ch = ch ^ ps2a_pkg::CASE_BIT;
        end
      end
    endcase
    return ch;
  endfunction

  always @(posedge clk) begin
    logic [6:0] want;
    if (rst) begin
      lshift_held = 1'b0;
      rshift_held = 1'b0;
      caps_active = 1'b0;
      phase = ps2a_pkg::PH_NONE;
      char_queue.delete();
    end else begin
      if (scan_valid && scan_ready) begin
        case (phase)
          ps2a_pkg::PH_NONE: begin
            if (scan_byte == ps2a_pkg::PREFIX_EXT) phase = ps2a_pkg::PH_EXT;
            else if (scan_byte == ps2a_pkg::PREFIX_REL) phase = ps2a_pkg::PH_REL;
            else char_queue.push_back(finish_code(scan_byte, 1'b0));
          end
          ps2a_pkg::PH_EXT: begin
            if (scan_byte == ps2a_pkg::PREFIX_REL) begin
              phase = ps2a_pkg::PH_REL;
            end else begin
              phase = ps2a_pkg::PH_NONE;
              char_queue.push_back(finish_code(scan_byte, 1'b1));
            end
          end
          default: begin
            phase = ps2a_pkg::PH_NONE;
            char_queue.push_back(finish_code(scan_byte, 1'b1));
          end
        endcase
      end
      if (char_valid && char_ready) begin
        if (char_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, ascii_char 0x%02h with none expected",
                   $time, ascii_char);
        end else begin
          want = char_queue.pop_front();
          checked++;
          if (ascii_char !== want) begin
            errors++;
            $display("%0t: ascii_char mismatch, expected 0x%02h, got 0x%02h",
                     $time, want, ascii_char);
          end
        end
      end
    end
    pending <= char_queue.size();
  end

endmodule

### dv/ps2_set2_scancode_to_ascii_test.sv
`timescale 1ns / 1ps

module ps2_set2_scancode_to_ascii_test;

  localparam int OPENING_LEN  = 27;
  localparam int RANDOM_ITEMS = 423;
  localparam int IDLE_PCT     = 29;
  localparam int CALM_FROM    = 150;
  localparam int CALM_TO      = 260;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst;
  logic calm;
  int   sent;
  int   cycles;
  int   errors;
  int   pending;
  int   checked;

  logic [7:0] opening [OPENING_LEN];

  ps2a_scan_if scan_ch ();
  ps2a_char_if char_ch ();

  ps2_set2_scancode_to_ascii uut (
    .clk   (clk),
    .rst   (rst),
    .scan  (scan_ch),
    .chars (char_ch)
  );

  ps2_set2_scancode_to_ascii_checker char_check (
    .clk        (clk),
    .rst        (rst),
    .scan_valid (scan_ch.valid),
    .scan_ready (scan_ch.ready),
    .scan_byte  (scan_ch.scan_byte),
    .char_valid (char_ch.valid),
    .char_ready (char_ch.ready),
    .ascii_char (char_ch.ascii_char),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycles, pending);
      $display("ps2_set2_scancode_to_ascii regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    char_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      gap = int'($urandom_range(1, 4));
      scan_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_ch.valid     <= 1'b1;
    scan_ch.scan_byte <= b;
    @(posedge clk);
    while (!scan_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(9) == 0) return 8'($urandom_range(132, 255));
    return 8'($urandom_range(0, 131));
  endfunction

  initial begin
    int         sel;
    logic [7:0] code;
    logic [7:0] key;
    rst               = 1'b1;
    calm              = 1'b0;
    sent              = 0;
    cycles            = 0;
    scan_ch.valid     = 1'b0;
    scan_ch.scan_byte = 8'h00;
    char_ch.ready     = 1'b0;
    // code zero, last code, first out-of-range code, shift, caps, and the
    // repeated and stacked prefix cases
    opening = '{8'h00, 8'h83, 8'h84, 8'h1C, ps2a_pkg::KEY_SPACE, ps2a_pkg::KEY_BKSP,
                ps2a_pkg::KEY_LSHIFT, 8'h1C, ps2a_pkg::PREFIX_REL, ps2a_pkg::KEY_LSHIFT,
                ps2a_pkg::KEY_CAPS, 8'h1C, ps2a_pkg::KEY_RSHIFT, 8'h1C,
                ps2a_pkg::PREFIX_REL, ps2a_pkg::KEY_RSHIFT, ps2a_pkg::PREFIX_EXT,
                ps2a_pkg::PREFIX_EXT, ps2a_pkg::PREFIX_EXT, ps2a_pkg::PREFIX_REL,
                ps2a_pkg::KEY_SPACE, ps2a_pkg::PREFIX_REL, ps2a_pkg::PREFIX_EXT,
                ps2a_pkg::PREFIX_REL, ps2a_pkg::PREFIX_REL, ps2a_pkg::KEY_CAPS,
                8'hFF};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < OPENING_LEN; i++) send_byte(opening[i]);

    while (sent < OPENING_LEN + RANDOM_ITEMS) begin
      calm <= (sent >= CALM_FROM) && (sent < CALM_TO);
      sel  = int'($urandom_range(99));
      code = pick_code();
      if (sel < 35) begin
        send_byte(code);
        if ($urandom_range(1)) begin
          send_byte(ps2a_pkg::PREFIX_REL);
          send_byte(code);
        end
      end else if (sel < 50) begin
        key = $urandom_range(1) ? ps2a_pkg::KEY_LSHIFT : ps2a_pkg::KEY_RSHIFT;
        if ($urandom_range(1)) begin
          send_byte(key);
        end else begin
          send_byte(ps2a_pkg::PREFIX_REL);
          send_byte(key);
        end
      end else if (sel < 57) begin
        send_byte(ps2a_pkg::KEY_CAPS);
        send_byte(ps2a_pkg::PREFIX_REL);
        send_byte(ps2a_pkg::KEY_CAPS);
      end else if (sel < 70) begin
        send_byte(ps2a_pkg::PREFIX_EXT);
        if ($urandom_range(1)) send_byte(ps2a_pkg::PREFIX_REL);
        send_byte(code);
      end else if (sel < 80) begin
        key = $urandom_range(1) ? ps2a_pkg::KEY_SPACE : ps2a_pkg::KEY_BKSP;
        send_byte(key);
        send_byte(ps2a_pkg::PREFIX_REL);
        send_byte(key);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end

    scan_ch.valid <= 1'b0;
    calm <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d scan bytes sent: directed corner codes, then random make/break,", sent);
    $display("shift, caps, extended and stray-byte sequences; %0d characters compared",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("ps2_set2_scancode_to_ascii regression: pass");
    end else begin
      $display("ps2_set2_scancode_to_ascii regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ps2a_pkg.sv
hw/rtl/ps2a_scan_if.sv
hw/rtl/ps2a_char_if.sv
hw/rtl/ps2a_xlate.sv
hw/rtl/ps2_set2_scancode_to_ascii.sv
dv/ps2_set2_scancode_to_ascii_checker.sv
dv/ps2_set2_scancode_to_ascii_test.sv
